FILE: rtl/core/fir_filter_49tap_saturating_core_assert.svh
// ----------------------------------------------------------------------------
// FIR core assertion macros
// Shared concurrent assertion shorthands, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_49TAP_SATURATING_CORE_ASSERT_SVH
`define FIR_FILTER_49TAP_SATURATING_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// condition holds at every edge
`define FIR49_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);
// antecedent implies consequent in the same cycle
`define FIR49_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define FIR49_ASSERT(lbl, cond, msg)
`define FIR49_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/core/fir49_pkg.sv
// ----------------------------------------------------------------------------
// FIR core package
// Defaults, coefficient ROM, width helpers and control structs.
// ----------------------------------------------------------------------------
package fir49_pkg;

  localparam int TAPS_DEF      = 49;
  localparam int COEF_FRAC_DEF = 16;
  localparam int ROM_LEN       = 49;
  localparam int ROM_FRAC      = 16;
  localparam int ROM_MAG_BITS  = 17;  // signed width of ROM entries

  localparam logic signed [15:0] SMP_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SMP_MIN = -16'sh8000;

  // Q.16 coefficients, symmetric
  localparam logic signed [31:0] COEF_ROM [ROM_LEN] = '{
    -32'sd860,   32'sd1732,   32'sd64,     -32'sd606,   -32'sd734,
    -32'sd512,   -32'sd58,    32'sd472,    32'sd854,    32'sd866,
    32'sd420,    -32'sd368,   -32'sd1160,  -32'sd1532,  -32'sd1164,
    -32'sd40,    32'sd1478,   32'sd2696,   32'sd2848,   32'sd1394,
    -32'sd1714,  -32'sd5920,  -32'sd10206, -32'sd13402, 32'sd50952,
    -32'sd13402, -32'sd10206, -32'sd5920,  -32'sd1714,  32'sd1394,
    32'sd2848,   32'sd2696,   32'sd1478,   -32'sd40,    -32'sd1164,
    -32'sd1532,  -32'sd1160,  -32'sd368,   32'sd420,    32'sd866,
    32'sd854,    32'sd472,    -32'sd58,    -32'sd512,   -32'sd734,
    -32'sd606,   32'sd64,     32'sd1732,   -32'sd860
  };

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  typedef struct packed {
    logic rd_en;
    logic rd_first;
    logic wr_en;
  } dl_ctl_t;

  function automatic int coef_w(input int frac);
    return ROM_MAG_BITS + ((frac > ROM_FRAC) ? (frac - ROM_FRAC) : 0);
  endfunction

  function automatic int acc_w(input int taps, input int frac);
    return 16 + coef_w(frac) + $clog2(taps);
  endfunction

  // coefficient of tap k rescaled to frac fraction bits, truncated toward zero
  function automatic logic signed [31:0] tap_coef(input int k, input int frac);
    logic signed [31:0] c;
    logic signed [31:0] q;
    logic signed [31:0] msk;
    int dn;
    if (k >= ROM_LEN) begin
      return '0;
    end
    c = COEF_ROM[k];
    if (frac >= ROM_FRAC) begin
      return c <<< (frac - ROM_FRAC);
    end
    dn  = ROM_FRAC - frac;
    q   = c >>> dn;
    msk = (32'sd1 <<< dn) - 32'sd1;
    if (c < 0 && (c & msk) != 0) begin
      q = q + 32'sd1;
    end
    return q;
  endfunction

endpackage

FILE: rtl/core/fir49_dline.sv
// ----------------------------------------------------------------------------
// FIR delay line
// Circular sample memory with a registered read; unwritten slots
// read as zero by way of a fill count.
// ----------------------------------------------------------------------------
`include "fir_filter_49tap_saturating_core_assert.svh"

module fir49_dline #(
  parameter int TAPS = fir49_pkg::TAPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fir49_pkg::dl_ctl_t        ctl_i,
  input  logic [$clog2(TAPS)-1:0]   rd_k_i,
  input  logic signed [15:0]        wr_data_i,
  output logic signed [15:0]        rd_q_o
);
  import fir49_pkg::*;

  localparam int DL  = TAPS - 1;
  localparam int ADW = (DL > 1) ? $clog2(DL) : 1;
  localparam int KW  = $clog2(TAPS);

  logic signed [15:0] mem [DL];
  logic signed [15:0] q_r;
  logic               use_r;
  logic [ADW-1:0]     wp_r, wp_nxt;
  logic [ADW-1:0]     ra_r;
  logic [ADW-1:0]     rd_addr, rd_base;
  logic [KW-1:0]      fill_r, fill_nxt;

  // tap 1 sits just behind the write pointer, later taps walk backward
  always_comb begin
    rd_base = ctl_i.rd_first ? wp_r : ra_r;
    rd_addr = (rd_base == '0) ? ADW'(DL - 1) : rd_base - 1'b1;
    wp_nxt  = (wp_r == ADW'(DL - 1)) ? '0 : wp_r + 1'b1;
    fill_nxt = (fill_r == KW'(DL)) ? fill_r : fill_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (ctl_i.wr_en) begin
      mem[wp_r] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      q_r   <= mem[rd_addr];
      use_r <= (rd_k_i <= fill_r);
      ra_r  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else if (ctl_i.wr_en) begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
    end
  end

  assign rd_q_o = use_r ? q_r : '0;

  `FIR49_ASSERT(a_fill_max, fill_r <= KW'(DL), "delay line fill count above depth")
  `FIR49_ASSERT(a_wp_range, wp_r <= ADW'(DL - 1), "delay line write pointer out of range")

endmodule

FILE: rtl/core/fir49_mac.sv
// ----------------------------------------------------------------------------
// FIR multiply-accumulate
// Registered product, exact accumulator, then round and saturate to 16 bits.
// ----------------------------------------------------------------------------
`include "fir_filter_49tap_saturating_core_assert.svh"

module fir49_mac #(
  parameter int TAPS           = fir49_pkg::TAPS_DEF,
  parameter int COEF_FRAC_BITS = fir49_pkg::COEF_FRAC_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  fir49_pkg::mac_ctl_t                               op_i,
  input  logic signed [15:0]                                smp_i,
  input  logic signed [fir49_pkg::coef_w(COEF_FRAC_BITS)-1:0] coef_i,
  output logic signed [15:0]                                res_o,
  output logic                                              done_o
);
  import fir49_pkg::*;

  localparam int CW = coef_w(COEF_FRAC_BITS);
  localparam int PW = 16 + CW;
  localparam int AW = acc_w(TAPS, COEF_FRAC_BITS);
  localparam int F  = COEF_FRAC_BITS;

  localparam logic signed [AW:0] HALF   = (AW+1)'(64'sd1 <<< (F - 1));
  localparam logic signed [AW:0] SAT_HI = (AW+1)'(64'sd32767 <<< F);
  localparam logic signed [AW:0] SAT_LO = (AW+1)'(-64'sd32768 <<< F);

  logic signed [PW-1:0] prod_r;
  logic                 pv_r, pfirst_r, plast_r;
  logic signed [AW-1:0] acc_r;
  logic                 accd_r;
  logic signed [15:0]   res_r, res_nxt;
  logic                 done_r;
  logic signed [AW:0]   acc_x, rnd_t, q_t;

  // stage 1: product
  always_ff @(posedge clk) begin
    prod_r   <= PW'(smp_i) * PW'(coef_i);
    pfirst_r <= op_i.first;
    plast_r  <= op_i.last;
  end

  // stage 2: accumulate
  always_ff @(posedge clk) begin
    if (pv_r) begin
      acc_r <= pfirst_r ? AW'(prod_r) : acc_r + AW'(prod_r);
    end
  end

  // stage 3: round half up, truncate toward zero, clamp
  always_comb begin
    acc_x = (AW+1)'(acc_r);
    rnd_t = acc_x + HALF;
    q_t   = rnd_t >>> F;
    if (rnd_t[AW] && (rnd_t[F-1:0] != '0)) begin
      q_t = q_t + 1'b1;
    end
    if (acc_x > SAT_HI) begin
      res_nxt = SMP_MAX;
    end else if (acc_x < SAT_LO) begin
      res_nxt = SMP_MIN;
    end else begin
      res_nxt = q_t[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accd_r) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r   <= 1'b0;
      accd_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      pv_r   <= op_i.valid;
      accd_r <= pv_r && plast_r;
      done_r <= accd_r;
    end
  end

  assign res_o  = res_r;
  assign done_o = done_r;

  `FIR49_ASSERT_IMPL(a_no_trailing_prod, accd_r, !pv_r, "product in flight after last tap")

endmodule

FILE: rtl/core/fir_filter_49tap_saturating_core.sv
// ----------------------------------------------------------------------------
// 49-tap saturating FIR core
// Direct-form FIR over 16-bit samples with a memory delay line and one
// shared multiply-accumulate; Q.16 coefficient ROM, round and saturate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_sample_in: one signed 16-bit sample
//   per transfer. Output channel out_valid/out_ready/out_sample_out: one
//   filtered sample per input sample, in order.
//   Timing: the accept cycle reads tap 1 and feeds tap 0 to the MAC; the
//   remaining TAPS-2 delay-line reads follow one per cycle from the single
//   memory read port. The read, product, accumulate and round registers lie
//   between the last read and out_valid, and no new sample is taken until
//   the result of the last one has loaded into the output register.
//   The memory read port and the one MAC serialize the taps of each sample.
//   The new sample is written to the delay line as the result loads into
//   the output register, so the next sample never overlaps a pending write.
//   Reset (rst_n low, synchronous): FSM idle, output empty, write pointer
//   and fill count zero, so the delay line reads as all zeros; no clearing
//   pass is needed.
//   Stall: a result waiting in the output register does not block the next
//   input transfer; the core only holds its finished result back until the
//   output register is free.
// ----------------------------------------------------------------------------
`include "fir_filter_49tap_saturating_core_assert.svh"

module fir_filter_49tap_saturating_core #(
  parameter int TAPS           = fir49_pkg::TAPS_DEF,
  parameter int COEF_FRAC_BITS = fir49_pkg::COEF_FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_sample_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample_out
);
  import fir49_pkg::*;

  localparam int DL = TAPS - 1;
  localparam int KW = $clog2(TAPS);
  localparam int CW = coef_w(COEF_FRAC_BITS);
  localparam logic signed [CW-1:0] COEF0 = CW'(tap_coef(0, COEF_FRAC_BITS));

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,  // waiting for a sample
    ST_RUN  = 4'b0010,  // issuing delay-line reads
    ST_WAIT = 4'b0100,  // MAC pipeline draining
    ST_HOLD = 4'b1000   // result ready, waiting for output register
  } fir_state_t;

  fir_state_t         state_r, state_nxt;
  logic [KW-1:0]      k_r, rd_k_r, rd_k;
  logic               rd_last, rd_v_r, rd_last_r;
  logic signed [15:0] x_r;
  logic               out_valid_r;
  logic signed [15:0] out_data_r;
  logic               in_xfer, hold_go;

  dl_ctl_t            dl_ctl;
  logic signed [15:0] dl_q;
  mac_ctl_t           mac_op;
  logic signed [15:0] mac_smp;
  logic signed [CW-1:0] mac_coef;
  logic signed [15:0] mac_res;
  logic               mac_done;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign hold_go  = (state_r == ST_HOLD) && (!out_valid_r || out_ready);

  // tap being read this cycle; tap 1 goes out with the accept
  assign rd_k    = (state_r == ST_IDLE) ? KW'(1) : k_r;
  assign rd_last = (rd_k == KW'(DL));

  always_comb begin
    dl_ctl.rd_en    = in_xfer || (state_r == ST_RUN);
    dl_ctl.rd_first = in_xfer;
    dl_ctl.wr_en    = hold_go;
  end

  // tap 0 takes the live sample; other taps come back from the memory
  always_comb begin
    if (in_xfer) begin
      mac_op.valid = 1'b1;
      mac_op.first = 1'b1;
      mac_op.last  = 1'b0;
      mac_smp      = in_sample_in;
      mac_coef     = COEF0;
    end else begin
      mac_op.valid = rd_v_r;
      mac_op.first = 1'b0;
      mac_op.last  = rd_last_r;
      mac_smp      = dl_q;
      mac_coef     = CW'(tap_coef(int'(rd_k_r), COEF_FRAC_BITS));
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = rd_last ? ST_WAIT : ST_RUN;
        end
      end
      ST_RUN: begin
        if (rd_last) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mac_done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (hold_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_v_r      <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_v_r    <= dl_ctl.rd_en;
      rd_last_r <= dl_ctl.rd_en && rd_last;
      if (hold_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dl_ctl.rd_en) begin
      k_r    <= rd_k + 1'b1;
      rd_k_r <= rd_k;
    end
    if (in_xfer) begin
      x_r <= in_sample_in;
    end
    if (hold_go) begin
      out_data_r <= mac_res;
    end
  end

  fir49_dline #(
    .TAPS (TAPS)
  ) u_dline (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (dl_ctl),
    .rd_k_i    (rd_k),
    .wr_data_i (x_r),
    .rd_q_o    (dl_q)
  );

  fir49_mac #(
    .TAPS           (TAPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .op_i   (mac_op),
    .smp_i  (mac_smp),
    .coef_i (mac_coef),
    .res_o  (mac_res),
    .done_o (mac_done)
  );

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

  `FIR49_ASSERT_IMPL(a_done_in_wait, mac_done, state_r == ST_WAIT, "MAC result outside drain")
  `FIR49_ASSERT_IMPL(a_wr_no_rd, dl_ctl.wr_en, !rd_v_r && !dl_ctl.rd_en, "write overlaps read")

endmodule

FILE: test/tb_fir_filter_49tap_saturating_core.sv
// ----------------------------------------------------------------------------
// 49-tap saturating FIR core testbench
// Sends signed 16-bit samples through the core. A local direct-form filter
// model computes each output with an exact 64-bit sum and the same round and
// clamp rule. Every output transfer is compared in order. Both channels
// get random idle and stall bursts.
// ----------------------------------------------------------------------------
module tb_fir_filter_49tap_saturating_core;

  // Filter shape at the core's default parameters
  localparam int     NTAPS      = 49;
  localparam int     FRAC       = 16;
  localparam longint UNITY      = longint'(1) <<< FRAC;
  localparam logic signed [15:0] PEAK_POS = 16'sh7FFF;
  localparam logic signed [15:0] PEAK_NEG = -16'sh8000;

  // No-transfer limit. It leaves a wide margin over the time one sample takes
  // in the core plus the longest idle and stall bursts.
  localparam int     HANG_LIMIT = 2000;

  // Cycles to watch for stray outputs once the last result is in.
  localparam int     SETTLE     = NTAPS + 12;

  // Q.16 tap weights, symmetric around tap 24
  int tap_weight [0:NTAPS-1] = '{
    -860,   1732,   64,     -606,   -734,   -512,   -58,    472,
    854,    866,    420,    -368,   -1160,  -1532,  -1164,  -40,
    1478,   2696,   2848,   1394,   -1714,  -5920,  -10206, -13402,
    50952,
    -13402, -10206, -5920,  -1714,  1394,   2848,   2696,   1478,
    -40,    -1164,  -1532,  -1160,  -368,   420,    866,    854,
    472,    -58,    -512,   -734,   -606,   64,     1732,   -860
  };

  logic               clk;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_sample_in = '0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic signed [15:0] out_sample_out;

  // Model state: past samples, entry 0 the newest
  logic signed [15:0] sample_history [0:NTAPS-2];

  // Filter outputs still owed by the core, oldest first
  logic signed [15:0] pending_outputs [$];

  int error_count  = 0;
  int result_count = 0;

  // Idle control: percent chance of a burst before each input transfer and
  // at each free output cycle. calm turns all idling off.
  int idle_pct   = 0;
  int stall_pct  = 0;
  bit calm       = 1'b0;
  int stall_left = 0;

  logic signed [15:0] due_sample;

  fir_filter_49tap_saturating_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Filter model: one call per accepted sample. Full-precision sum over all
  // taps, then shift the sample into the history. Clamp outside the 16-bit
  // range, otherwise add half an LSB and divide (truncates toward zero).
  // --------------------------------------------------------------------------
  function automatic logic signed [15:0] filter_sample(input logic signed [15:0] x);
    longint acc;
    acc = longint'(x) * tap_weight[0];
    for (int k = 1; k < NTAPS; k++) begin
      acc += longint'(sample_history[k-1]) * tap_weight[k];
    end
    for (int k = NTAPS - 2; k > 0; k--) begin
      sample_history[k] = sample_history[k-1];
    end
    sample_history[0] = x;
    if (acc > 32767 * UNITY) begin
      return PEAK_POS;
    end
    if (acc < -32768 * UNITY) begin
      return PEAK_NEG;
    end
    return 16'((acc + UNITY / 2) / UNITY);
  endfunction

  task automatic report_mismatch(input string what, input logic signed [15:0] got,
                                 input logic signed [15:0] want);
    $display("MISMATCH %s: result %0d got %0d expected %0d",
             what, result_count, got, want);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Input side: optional idle burst, then hold valid and data until the
  // transfer. Valid stays high on return so back-to-back samples never see
  // valid drop and rise in the same step.
  // --------------------------------------------------------------------------
  task automatic send_sample(input logic signed [15:0] x);
    int gap;
    if (!calm && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_outputs.push_back(filter_sample(x));
  endtask

  // Mix of full-range, tiny (rounding), rail and near-rail values
  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'(int'($urandom_range(128)) - 64);
      2: return ($urandom_range(1)) ? PEAK_POS : PEAK_NEG;
      default: return ($urandom_range(1)) ? 16'($urandom_range(32767, 24000))
                                          : 16'(-int'($urandom_range(32768, 24000)));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random stall bursts unless calm
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      stall_left <= $urandom_range(6);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker: each output transfer against the oldest owed sample
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch("unexpected output", out_sample_out, '0);
      end else begin
        due_sample = pending_outputs.pop_front();
        if (out_sample_out !== due_sample) begin
          report_mismatch("sample_out", out_sample_out, due_sample);
        end
      end
      result_count++;
    end
  end

  // Watchdog: ends the run if nothing moves on either channel for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("TIMEOUT: no transfer for %0d cycles", HANG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Rails, zero, single LSB steps, alternating bit patterns, sign flips
  // between full-scale samples
  task automatic test_extremes();
    logic signed [15:0] vals [$];
    vals = '{PEAK_POS, 16'sd0, 16'sd0, PEAK_NEG, 16'sd0, 16'sd1, -16'sd1,
             PEAK_POS, PEAK_POS, PEAK_NEG, PEAK_NEG, 16'sh5555, 16'shAAAA,
             16'sd256, -16'sd256, PEAK_POS, PEAK_NEG, 16'sd0};
    idle_pct  = 0;
    stall_pct = 0;
    foreach (vals[i]) send_sample(vals[i]);
  endtask

  // Random samples in chunks; each chunk draws its own idle and stall odds,
  // often zero so there are stretches with no idling at all
  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        idle_pct  = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 40);
        stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 40);
      end
      send_sample(random_sample());
    end
  endtask

  // Runs of a full window whose signs follow the tap weights, so the sum
  // builds up coherently and clamps at one rail. The magnitude range of
  // each run decides whether it just reaches the rail or goes far past it.
  task automatic test_saturation_runs(input int runs);
    int polarity;
    int mag_lo;
    int mag;
    int k;
    idle_pct  = 20;
    stall_pct = 20;
    for (int r = 0; r < runs; r++) begin
      polarity = (r % 2 == 0) ? 1 : -1;
      mag_lo   = $urandom_range(12000, 30000);
      for (int j = 0; j < NTAPS; j++) begin
        k   = NTAPS - 1 - j;  // tap this sample will sit on at the window's end
        mag = $urandom_range(32767, mag_lo);
        if ((tap_weight[k] >= 0) == (polarity > 0)) begin
          send_sample(16'(mag));
        end else begin
          // negative side may reach the bottom rail
          send_sample(16'(-((mag == 32767) ? 32768 : mag)));
        end
      end
    end
  endtask

  // Sender stops until every owed output has arrived, then resumes
  task automatic test_drain_pause();
    test_random_mix(30);
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    test_random_mix(30);
  endtask

  // Last stretch: no idling on either side
  task automatic test_back_to_back(input int count);
    calm = 1'b1;
    for (int i = 0; i < count; i++) begin
      send_sample(random_sample());
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < NTAPS - 1; k++) begin
      sample_history[k] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_random_mix(200);
    test_saturation_runs(4);
    test_drain_pause();
    test_random_mix(60);
    test_back_to_back(30);

    // drain, then watch a little longer for stray outputs
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
